/* hdl/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate block
// Field widths, request codes, register map and the structs that pass
// between the register file, the MAC unit and the top-level sequencer.
// ----------------------------------------------------------------------------
package mma_pkg;

   // default geometry and number format
   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field widths of the channels
   localparam int KIND_W = 2;
   localparam int ROW_W  = 3;
   localparam int VAL_W  = 32;
   localparam int CFG_W  = 4;

   // APB register port
   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;

   // request codes
   localparam logic [KIND_W-1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_LOAD_C  = 2'd2;
   localparam logic [KIND_W-1:0] REQ_COMPUTE = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] CFG_ROWS_A    = 2'd0;
   localparam logic [1:0] CFG_INNER_DIM = 2'd1;
   localparam logic [1:0] CFG_COLS_B    = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   typedef struct packed {
      logic [KIND_W-1:0]       req_type;
      logic [ROW_W-1:0]        row;
      logic [ROW_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic [ROW_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] rows_a;
      logic [CFG_W-1:0] inner_dim;
      logic [CFG_W-1:0] cols_b;
   } cfg_type;

   // per-cycle commands from the sequencer to the MAC unit
   typedef struct packed {
      logic load;     // seed the accumulator with the C entry
      logic mul_lo;   // multiply A by the low half of B
      logic mul_hi;   // multiply A by the high half of B
   } mac_ctl_type;

endpackage

/* hdl/matrix_multiply_accumulate.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: C += A x B on signed fixed-point matrices
//
// Request channel (req_valid/req_ready/req_data): load items write one
// element of A, B or C. A compute item walks C in
// row-major order and emits one result per entry on the response channel
// (rsp_valid/rsp_ready/rsp_data), with last set on the final entry.
// req_ready is high only while no compute is running.
// Each C entry takes a read step, a low-half and a high-half multiply per
// product on the shared half-width multiplier, a drain of the join/add
// steps and a write-back; with inner_dim at zero only the read, the
// seeding low-half step, the drain and the write-back remain.
// A single output register holds the latest result; while the receiver
// stalls, the write-back of the next entry waits and the walk holds.
// Loads may be taken while the last result still waits.
// Reset clears C to zero (per-entry valid bits, no clearing pass), sets all
// dimension registers to 8 and empties the output register. A and B hold
// no value until written. The user must write the dimension registers
// over APB only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
   parameter int MAX_DIM    = mma_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mma_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mma_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mma_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mma_pkg::rsp_item_type          rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mma_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [mma_pkg::APB_DATA_W-1:0] pwdata,
   output logic [mma_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);
   import mma_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_MLO   = 3'd2;
   localparam logic [2:0] S_MHI   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;

   cfg_type                cfg;
   mac_ctl_type            mac_ctl;
   logic                   mac_busy;
   logic [DATA_WIDTH-1:0]  mac_result;

   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]       nr_eff, nk_eff, nc_eff;
   logic                   req_fire, load_fire, comp_fire, in_range;
   logic                   more_k, last_entry, last_col, wb_fire;

   logic [DATA_WIDTH-1:0]  a_mem [DEPTH];
   logic [DATA_WIDTH-1:0]  b_mem [DEPTH];
   logic [DATA_WIDTH-1:0]  c_mem [DEPTH];
   logic [DEPTH-1:0]       c_valid_ff;
   logic [DATA_WIDTH-1:0]  a_rd_ff, b_rd_ff, c_rd_ff;
   logic                   c_rv_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_k;
   logic [ADDR_W-1:0]      ld_addr, c_wr_addr;
   logic [DATA_WIDTH-1:0]  ld_word, c_wr_data;
   logic                   c_wr_en;

   mma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // dimension registers above MAX_DIM act as MAX_DIM
   assign nr_eff = (int'(cfg.rows_a) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.rows_a);
   assign nk_eff = (int'(cfg.inner_dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.inner_dim);
   assign nc_eff = (int'(cfg.cols_b) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.cols_b);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign comp_fire = req_fire && (req_data.req_type == REQ_COMPUTE);
   assign in_range  = (int'(req_data.row) < MAX_DIM) && (int'(req_data.col) < MAX_DIM);
   assign load_fire = req_fire && (req_data.req_type != REQ_COMPUTE) && in_range;
   assign ld_addr   = {IDX_W'(req_data.row), IDX_W'(req_data.col)};
   assign ld_word   = DATA_WIDTH'($unsigned(req_data.value));

   assign more_k     = (DIM_W'(k_ff) + DIM_W'(1)) < nk_eff;
   assign last_col   = (DIM_W'(j_ff) + DIM_W'(1)) == nc_eff;
   assign last_entry = last_col && ((DIM_W'(i_ff) + DIM_W'(1)) == nr_eff);
   assign wb_fire    = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);

   // ---- operand stores -----------------------------------------------------
   assign rd_en = (state_ff == S_READ) || ((state_ff == S_MHI) && more_k);
   assign rd_k  = (state_ff == S_READ) ? '0 : k_ff + IDX_W'(1);

   assign c_wr_en   = (load_fire && (req_data.req_type == REQ_LOAD_C)) || wb_fire;
   assign c_wr_addr = wb_fire ? {i_ff, j_ff} : ld_addr;
   assign c_wr_data = wb_fire ? mac_result : ld_word;

   always_ff @(posedge clock) begin
      if (load_fire && (req_data.req_type == REQ_LOAD_A)) begin
         a_mem[ld_addr] <= ld_word;
      end
      if (load_fire && (req_data.req_type == REQ_LOAD_B)) begin
         b_mem[ld_addr] <= ld_word;
      end
      if (c_wr_en) begin
         c_mem[c_wr_addr] <= c_wr_data;
      end
      if (rd_en) begin
         a_rd_ff <= a_mem[{i_ff, rd_k}];
         b_rd_ff <= b_mem[{rd_k, j_ff}];
         c_rd_ff <= c_mem[{i_ff, j_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= '0;
         c_rv_ff    <= 1'b0;
      end else begin
         if (c_wr_en) begin
            c_valid_ff[c_wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            c_rv_ff <= c_valid_ff[{i_ff, j_ff}];
         end
      end
   end

   // ---- shared MAC ---------------------------------------------------------
   always_comb begin
      mac_ctl        = '0;
      mac_ctl.load   = (state_ff == S_MLO) && (k_ff == '0);
      mac_ctl.mul_lo = (state_ff == S_MLO);
      mac_ctl.mul_hi = (state_ff == S_MHI);
   end

   mma_mac #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .op_a   (a_rd_ff),
      .op_b   (b_rd_ff),
      .init   (c_rv_ff ? c_rd_ff : '0),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (comp_fire && (nr_eff != '0) && (nc_eff != '0)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MLO;
         end
         S_MLO: begin
            state_in = (nk_eff == '0) ? S_DRAIN : S_MHI;
         end
         S_MHI: begin
            if (more_k) begin
               k_in     = k_ff + IDX_W'(1);
               state_in = S_MLO;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!mac_busy) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (wb_fire) begin
               k_in = '0;
               if (last_entry) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
                  if (last_col) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- output register ----------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (wb_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_row   = ROW_W'(i_ff);
         rsp_data_in.out_col   = ROW_W'(j_ff);
         rsp_data_in.out_value = VAL_W'(mac_result);
         rsp_data_in.last      = last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks -------------------------------------------------------------
   a_wb_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> !mac_busy)
      else $error("write-back while MAC still has pending steps");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> ((DIM_W'(i_ff) < nr_eff) && (DIM_W'(j_ff) < nc_eff)))
      else $error("C walk index outside the configured size");

   a_k_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MHI) |-> (DIM_W'(k_ff) < nk_eff))
      else $error("inner index outside the configured size");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (comp_fire && (nr_eff != '0) && (nc_eff != '0)) |=> (state_ff == S_READ))
      else $error("compute transfer did not start the walk");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule

/* hdl/mma_csr.sv */
// ----------------------------------------------------------------------------
// mma_csr: APB register file
// Holds the three dimension registers; writes land on the access phase,
// reads return the register value, pready is tied high.
// ----------------------------------------------------------------------------
module mma_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mma_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [mma_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [mma_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                pready,
   output mma_pkg::cfg_type                    cfg
);
   import mma_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] index;
   logic       wr_en;

   assign index  = paddr[APB_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CFG_ROWS_A:    cfg_in.rows_a    = pwdata[CFG_W-1:0];
            CFG_INNER_DIM: cfg_in.inner_dim = pwdata[CFG_W-1:0];
            CFG_COLS_B:    cfg_in.cols_b    = pwdata[CFG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rows_a: CFG_RESET, inner_dim: CFG_RESET, cols_b: CFG_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         CFG_ROWS_A:    prdata = APB_DATA_W'(cfg_ff.rows_a);
         CFG_INNER_DIM: prdata = APB_DATA_W'(cfg_ff.inner_dim);
         CFG_COLS_B:    prdata = APB_DATA_W'(cfg_ff.cols_b);
         default:       prdata = '0;
      endcase
   end

endmodule

/* hdl/mma_mac.sv */
// ----------------------------------------------------------------------------
// mma_mac: shared fixed-point multiply-accumulate unit
// One signed multiplier takes A times half of B per cycle; the halves are
// joined, shifted down by the fraction width (floor), clamped if wider than
// LIM_B + 2 bits and added into a wide accumulator. The result output is the
// accumulator saturated to the data width.
// ----------------------------------------------------------------------------
module mma_mac #(
   parameter int MAX_DIM    = mma_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mma_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mma_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mma_pkg::mac_ctl_type  ctl,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   input  logic [DATA_WIDTH-1:0] init,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] result
);
   import mma_pkg::*;

   localparam int HB     = DATA_WIDTH / 2;
   localparam int HI_W   = DATA_WIDTH - HB;
   localparam int MB_W   = HI_W + 1;
   localparam int PM_W   = DATA_WIDTH + MB_W;
   localparam int FULL_W = 2 * DATA_WIDTH;
   localparam int TW     = FULL_W - FRAC_BITS;
   localparam int LIM_B  = 58;
   localparam int PW     = (TW > LIM_B + 1) ? LIM_B + 2 : TW;
   localparam int ACC_W  = ((PW > DATA_WIDTH) ? PW : DATA_WIDTH) + $clog2(MAX_DIM) + 1;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [MB_W-1:0]   b_sel;
   logic signed [PM_W-1:0]   prod;
   logic signed [PM_W-1:0]   p_lo_ff;
   logic signed [PM_W-1:0]   p_hi_ff;
   logic signed [FULL_W-1:0] full;
   logic signed [TW-1:0]     full_sh;
   logic signed [PW-1:0]     term_in;
   logic signed [PW-1:0]     term_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     sum_v_ff;
   logic                     add_v_ff;

   // low half is unsigned, high half carries the sign
   always_comb begin
      if (ctl.mul_hi) begin
         b_sel = {op_b[DATA_WIDTH-1], op_b[DATA_WIDTH-1:HB]};
      end else begin
         b_sel = {{(MB_W - HB){1'b0}}, op_b[HB-1:0]};
      end
   end

   assign prod = $signed(op_a) * b_sel;

   always_ff @(posedge clock) begin
      if (ctl.mul_lo) begin
         p_lo_ff <= prod;
      end
      if (ctl.mul_hi) begin
         p_hi_ff <= prod;
      end
   end

   assign full = ({{(FULL_W - PM_W){p_hi_ff[PM_W-1]}}, p_hi_ff} <<< HB)
               + {{(FULL_W - PM_W){p_lo_ff[PM_W-1]}}, p_lo_ff};
   assign full_sh = full[FULL_W-1:FRAC_BITS];

   generate
      if (TW > PW) begin : g_clamp
         localparam logic signed [TW-1:0] PLIM =
            {{(TW - LIM_B - 1){1'b0}}, 1'b1, {LIM_B{1'b0}}};
         localparam logic signed [TW-1:0] NLIM = -PLIM;
         always_comb begin
            if (full_sh > PLIM) begin
               term_in = PLIM[PW-1:0];
            end else if (full_sh < NLIM) begin
               term_in = NLIM[PW-1:0];
            end else begin
               term_in = full_sh[PW-1:0];
            end
         end
      end else begin : g_noclamp
         assign term_in = full_sh;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (sum_v_ff) begin
         term_ff <= term_in;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = {{(ACC_W - DATA_WIDTH){init[DATA_WIDTH-1]}}, init};
      end else if (add_v_ff) begin
         acc_in = acc_ff + {{(ACC_W - PW){term_ff[PW-1]}}, term_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // pending steps behind a high-half multiply: join, then add
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
         add_v_ff <= 1'b0;
      end else begin
         sum_v_ff <= ctl.mul_hi;
         add_v_ff <= sum_v_ff;
      end
   end

   assign busy = sum_v_ff || add_v_ff;

   always_comb begin
      if (acc_ff > SAT_HI) begin
         result = SAT_HI[DATA_WIDTH-1:0];
      end else if (acc_ff < SAT_LO) begin
         result = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         result = acc_ff[DATA_WIDTH-1:0];
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for matrix_multiply_accumulate
// Loads A, B and C elements over the request channel, runs computes under
// a range of dimension settings and checks every emitted C entry against a
// fixed-point model of C += A x B kept in the bench. Both channels idle at
// random; one phase holds the response side off long enough to back up the
// request side. Dimension registers are written and read back over APB.
// ----------------------------------------------------------------------------
module tb_top;
   import mma_pkg::*;

   localparam int MAX_DIM           = MAX_DIM_DEF;
   localparam int FRAC              = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES     = 2 * MAX_DIM + 6 + 8;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int RANDOM_ITEMS      = 40;
   localparam int CYCLE_LIMIT       = 600000;

   localparam logic [1:0]       CFG_UNUSED = 2'd3;
   localparam logic [VAL_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] Q_MIN      = 32'h8000_0000;
   localparam longint           SUM_HI     = 64'sd2147483647;
   localparam longint           SUM_LO     = -64'sd2147483648;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_item_type          rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   // bench copy of the block state
   logic signed [VAL_W-1:0] mat_a [MAX_DIM*MAX_DIM];
   logic signed [VAL_W-1:0] mat_b [MAX_DIM*MAX_DIM];
   logic signed [VAL_W-1:0] mat_c [MAX_DIM*MAX_DIM];
   bit                      a_written [MAX_DIM*MAX_DIM];
   bit                      b_written [MAX_DIM*MAX_DIM];
   logic [CFG_W-1:0]        dim_rows;
   logic [CFG_W-1:0]        dim_inner;
   logic [CFG_W-1:0]        dim_cols;

   rsp_item_type pending_entries [$];
   bit           mismatch_seen;
   bit           long_stall_request;
   int unsigned  items_sent;
   int unsigned  burst_left;
   int unsigned  cycle_count;

   matrix_multiply_accumulate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // model of C += A x B
   // ---------------------------------------------------------------------
   function automatic int eff_dim(logic [CFG_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   task automatic apply_request(req_item_type item);
      int           idx, nr, nk, nc, i, j, k;
      longint       acc;
      rsp_item_type entry;
      idx = int'(item.row) * MAX_DIM + int'(item.col);
      case (item.req_type)
         REQ_LOAD_A: begin
            mat_a[idx]     = item.value;
            a_written[idx] = 1'b1;
         end
         REQ_LOAD_B: begin
            mat_b[idx]     = item.value;
            b_written[idx] = 1'b1;
         end
         REQ_LOAD_C: begin
            mat_c[idx] = item.value;
         end
         default: begin
            nr = eff_dim(dim_rows);
            nk = eff_dim(dim_inner);
            nc = eff_dim(dim_cols);
            for (i = 0; i < nr; i++) begin
               for (j = 0; j < nc; j++) begin
                  acc = longint'(mat_c[i*MAX_DIM + j]);
                  // floor each exact product back to the word's fraction
                  for (k = 0; k < nk; k++) begin
                     acc += (longint'(mat_a[i*MAX_DIM + k]) *
                             longint'(mat_b[k*MAX_DIM + j])) >>> FRAC;
                  end
                  if (acc > SUM_HI) acc = SUM_HI;
                  if (acc < SUM_LO) acc = SUM_LO;
                  mat_c[i*MAX_DIM + j] = acc[VAL_W-1:0];
                  entry.out_row   = ROW_W'(i);
                  entry.out_col   = ROW_W'(j);
                  entry.out_value = acc[VAL_W-1:0];
                  entry.last      = (i == nr - 1) && (j == nc - 1);
                  pending_entries.push_back(entry);
               end
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected result: row %0d col %0d value %0d", rsp_data.out_row,
                   rsp_data.out_col, rsp_data.out_value);
            mismatch_seen = 1'b1;
         end else begin
            want = pending_entries.pop_front();
            if (rsp_data.out_row !== want.out_row) begin
               $error("out_row: expected %0d, got %0d", want.out_row, rsp_data.out_row);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.out_col !== want.out_col) begin
               $error("out_col: expected %0d, got %0d", want.out_col, rsp_data.out_col);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value,
                      rsp_data.out_value);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   // receiver: rotate through stall patterns, or hold off on request
   initial begin : response_stalls
      int unsigned tick;
      rsp_ready = 1'b0;
      tick      = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES - 1) @(posedge clock);
         end else begin
            case ((tick / 97) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_item_type make_item(logic [KIND_W-1:0] kind, int r, int c,
                                              logic [VAL_W-1:0] v);
      req_item_type item;
      item.req_type = kind;
      item.row      = ROW_W'(r);
      item.col      = ROW_W'(c);
      item.value    = v;
      return item;
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return VAL_W'($urandom_range(0, 2)) - 1;
         3, 4:    return $urandom();
         default: return VAL_W'($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   // row, col and value of a compute carry no meaning: fill them at random
   function automatic req_item_type compute_item();
      return make_item(REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
   endfunction

   function automatic req_item_type random_load();
      logic [KIND_W-1:0] kind;
      int                lim_r, lim_c, r, c;
      case ($urandom_range(0, 2))
         0: begin
            kind  = REQ_LOAD_A;
            lim_r = eff_dim(dim_rows);
            lim_c = eff_dim(dim_inner);
         end
         1: begin
            kind  = REQ_LOAD_B;
            lim_r = eff_dim(dim_inner);
            lim_c = eff_dim(dim_cols);
         end
         default: begin
            kind  = REQ_LOAD_C;
            lim_r = eff_dim(dim_rows);
            lim_c = eff_dim(dim_cols);
         end
      endcase
      if (lim_r > 0 && lim_c > 0 && $urandom_range(0, 1) == 1) begin
         r = $urandom_range(0, lim_r - 1);
         c = $urandom_range(0, lim_c - 1);
      end else begin
         r = $urandom_range(0, 7);
         c = $urandom_range(0, 7);
      end
      return make_item(kind, r, c, rand_value());
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 11))
         0:       return 4'd0;
         1:       return 4'd8;
         2:       return CFG_W'($urandom_range(9, 15));
         3, 4:    return CFG_W'($urandom_range(4, 7));
         default: return CFG_W'($urandom_range(1, 3));
      endcase
   endfunction

   // one transfer on the request channel, in bursts with random gaps
   task automatic send_item(req_item_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      apply_request(item);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_entries.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] dim);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      // upper data bits are don't-care for a 4-bit register
      pwdata  <= {(($urandom_range(0, 1) == 1) ? 28'($urandom()) : 28'd0), dim};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         CFG_ROWS_A:    dim_rows  = dim;
         CFG_INNER_DIM: dim_inner = dim;
         CFG_COLS_B:    dim_cols  = dim;
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(logic [1:0] index, logic [CFG_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CFG_W-1:0] !== want) begin
         $error("prdata[%0d]: expected %0d, got %0d", index, want, prdata[CFG_W-1:0]);
         mismatch_seen = 1'b1;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
      wait_for_results();
      write_reg(CFG_ROWS_A, r);
      write_reg(CFG_INNER_DIM, k);
      write_reg(CFG_COLS_B, c);
   endtask

   // never let a compute read an A or B entry that holds nothing yet
   task automatic load_missing_operands();
      int nr, nk, nc, i, j;
      nr = eff_dim(dim_rows);
      nk = eff_dim(dim_inner);
      nc = eff_dim(dim_cols);
      for (i = 0; i < nr; i++)
         for (j = 0; j < nk; j++)
            if (!a_written[i*MAX_DIM + j])
               send_item(make_item(REQ_LOAD_A, i, j, rand_value()));
      for (i = 0; i < nk; i++)
         for (j = 0; j < nc; j++)
            if (!b_written[i*MAX_DIM + j])
               send_item(make_item(REQ_LOAD_B, i, j, rand_value()));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_register_access();
      check_reg(CFG_ROWS_A, CFG_RESET);
      check_reg(CFG_INNER_DIM, CFG_RESET);
      check_reg(CFG_COLS_B, CFG_RESET);
      write_reg(CFG_ROWS_A, 4'd15);
      write_reg(CFG_INNER_DIM, 4'd0);
      write_reg(CFG_COLS_B, 4'd5);
      // an address past the register list must change nothing
      write_reg(CFG_UNUSED, 4'd3);
      check_reg(CFG_ROWS_A, 4'd15);
      check_reg(CFG_INNER_DIM, 4'd0);
      check_reg(CFG_COLS_B, 4'd5);
   endtask

   task automatic test_saturation();
      set_dims(4'd1, 4'd1, 4'd1);
      // C starts cleared; largest positive square clips high
      send_item(make_item(REQ_LOAD_A, 0, 0, Q_MAX));
      send_item(make_item(REQ_LOAD_B, 0, 0, Q_MAX));
      send_item(compute_item());
      send_item(compute_item());
      // most negative C plus a huge negative product clips low
      send_item(make_item(REQ_LOAD_C, 0, 0, Q_MIN));
      send_item(make_item(REQ_LOAD_A, 0, 0, Q_MIN));
      send_item(compute_item());
      // smallest negative product floors to -1 lsb
      send_item(make_item(REQ_LOAD_C, 0, 0, '0));
      send_item(make_item(REQ_LOAD_A, 0, 0, '1));
      send_item(make_item(REQ_LOAD_B, 0, 0, 32'd1));
      send_item(compute_item());
      // most negative squared is positive
      send_item(make_item(REQ_LOAD_A, 0, 0, Q_MIN));
      send_item(make_item(REQ_LOAD_B, 0, 0, Q_MIN));
      send_item(make_item(REQ_LOAD_C, 7, 7, Q_MAX));
      send_item(compute_item());
      wait_for_results();
   endtask

   task automatic test_zero_dims();
      set_dims(4'd0, 4'd1, 4'd1);
      send_item(compute_item());
      set_dims(4'd1, 4'd1, 4'd0);
      send_item(compute_item());
      // no inner products: C comes back unchanged
      set_dims(4'd2, 4'd0, 4'd3);
      send_item(make_item(REQ_LOAD_C, 1, 2, Q_MIN));
      send_item(compute_item());
      wait_for_results();
   endtask

   task automatic test_oversize_dims();
      set_dims(4'd12, 4'd1, 4'd1);
      load_missing_operands();
      send_item(compute_item());
      set_dims(4'd1, 4'd15, 4'd1);
      load_missing_operands();
      send_item(compute_item());
      set_dims(4'd1, 4'd1, 4'd9);
      load_missing_operands();
      send_item(compute_item());
      wait_for_results();
   endtask

   task automatic test_backpressure();
      set_dims(4'd4, 4'd2, 4'd4);
      load_missing_operands();
      long_stall_request = 1'b1;
      send_item(compute_item());
      send_item(random_load());
      send_item(compute_item());
      send_item(compute_item());
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int unsigned target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         set_dims(pick_dim(), pick_dim(), pick_dim());
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 6)) send_item(random_load());
            load_missing_operands();
            send_item(compute_item());
         end
         // trailing loads right behind the compute, taken once its walk ends
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_item(random_load());
      end
      wait_for_results();
   endtask

   task automatic test_full_size();
      set_dims(4'd8, 4'd2, 4'd8);
      load_missing_operands();
      send_item(compute_item());
      send_item(compute_item());
      wait_for_results();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      mismatch_seen      = 1'b0;
      long_stall_request = 1'b0;
      items_sent         = 0;
      burst_left         = 0;
      cycle_count        = 0;
      dim_rows           = CFG_RESET;
      dim_inner          = CFG_RESET;
      dim_cols           = CFG_RESET;
      foreach (mat_c[n]) begin
         mat_a[n]     = '0;
         mat_b[n]     = '0;
         mat_c[n]     = '0;
         a_written[n] = 1'b0;
         b_written[n] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_saturation();
      test_zero_dims();
      test_oversize_dims();
      test_backpressure();
      test_random_traffic();
      test_full_size();

      wait_for_results();
      if (mismatch_seen)
         $display("Mismatches found");
      else
         $display("No mismatches found");
      $finish;
   end

endmodule
